// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/ali_pkg.sv =====
// ----------------------------------------------------------------------------
// ali_pkg
// types, constants and control structs of the ordered list block
// ----------------------------------------------------------------------------
package ali_pkg;

    // store geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int ST_W     = 2;
    localparam int START_W  = 11;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_MAXIMUM = 3'd4,
        CMD_RESTART = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // channel payloads
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_in;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] data_out;
        logic [START_W-1:0]       current_length;
    } out_item_t;

    // datapath selectors
    typedef enum logic [2:0] {
        WA_IDX, WA_IDX_D_P1, WA_IDX_D_M1, WA_POS, WA_LAST
    } waddr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO, WD_DIN, WD_RDATA
    } wdata_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_LOAD_POS, IDX_LOAD_POS_P1, IDX_LOAD_LAST, IDX_LOAD_ZERO,
        IDX_INC, IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD, LEN_INC, LEN_DEC, LEN_START
    } len_op_t;

    typedef enum logic [1:0] {
        OUT_ZERO, OUT_RDATA, OUT_DIN, OUT_MAX
    } out_sel_t;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       mem_we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        idx_op_t    idx_op;
        len_op_t    len_op;
        logic       max_clr;
        logic       max_upd;
        logic       out_load;
        out_sel_t   out_sel;
        status_t    out_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             pos_ge_len;
        logic             pos_gt_len;
        logic             pos_p1_eq_len;
        logic             len_zero;
        logic             len_full;
        logic             idx_eq_pos;
        logic             idx_eq_last;
        logic             idx_eq_top;
        logic             rd_valid;
    } dp_stat_t;

endpackage

// ===== rtl/ali_dpath.sv =====
// ----------------------------------------------------------------------------
// ali_dpath
// entry store, length register, index counter, maximum and output register
// ----------------------------------------------------------------------------
module ali_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ali_pkg::in_item_t              s_item,
    input  logic                           cfg_wr_en,
    input  logic [ali_pkg::START_W-1:0]    cfg_wr_data,
    input  ali_pkg::dp_cmd_t               cmd,
    output ali_pkg::dp_stat_t              stat,
    output ali_pkg::out_item_t             m_item
);

    localparam int ADDR_W = ali_pkg::ADDR_W;
    localparam int LEN_W  = ali_pkg::LEN_W;
    localparam int DATA_W = ali_pkg::DATA_W;

    logic [DATA_W-1:0]        mem [ali_pkg::CAPACITY];
    logic [DATA_W-1:0]        rdata_reg;
    logic                     rd_valid_reg;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        idx_d_reg;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [ali_pkg::START_W-1:0] start_len_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic                     max_have_reg;
    ali_pkg::in_item_t        item_reg;
    ali_pkg::out_item_t       out_reg;

    logic [LEN_W-1:0]         pos_ext;
    logic [LEN_W-1:0]         len_m1;
    logic [ADDR_W-1:0]        pos_addr;
    logic [ADDR_W-1:0]        waddr;
    logic [DATA_W-1:0]        wdata;
    logic [LEN_W-1:0]         start_sat;
    logic signed [DATA_W-1:0] out_data;

    assign pos_ext  = LEN_W'(item_reg.position);
    assign pos_addr = ADDR_W'(item_reg.position);
    assign len_m1   = len_reg - LEN_W'(1);

    // status back to the controller
    assign stat.command       = item_reg.command;
    assign stat.pos_ge_len    = (pos_ext >= len_reg);
    assign stat.pos_gt_len    = (pos_ext > len_reg);
    assign stat.pos_p1_eq_len = ((pos_ext + LEN_W'(1)) == len_reg);
    assign stat.len_zero      = (len_reg == '0);
    assign stat.len_full      = (len_reg == LEN_W'(ali_pkg::CAPACITY));
    assign stat.idx_eq_pos    = (idx_reg == pos_addr);
    assign stat.idx_eq_last   = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    assign stat.idx_eq_top    = (idx_reg == ADDR_W'(ali_pkg::CAPACITY - 1));
    assign stat.rd_valid      = rd_valid_reg;

    // write address and data select
    always_comb begin
        case (cmd.waddr_sel)
            ali_pkg::WA_IDX:      waddr = idx_reg;
            ali_pkg::WA_IDX_D_P1: waddr = idx_d_reg + ADDR_W'(1);
            ali_pkg::WA_IDX_D_M1: waddr = idx_d_reg - ADDR_W'(1);
            ali_pkg::WA_POS:      waddr = pos_addr;
            ali_pkg::WA_LAST:     waddr = len_m1[ADDR_W-1:0];
            default:              waddr = idx_reg;
        endcase
        case (cmd.wdata_sel)
            ali_pkg::WD_DIN:   wdata = item_reg.data_in;
            ali_pkg::WD_RDATA: wdata = rdata_reg;
            default:           wdata = '0;
        endcase
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[idx_reg];
            idx_d_reg <= idx_reg;
        end
    end

    // index counter next value
    always_comb begin
        case (cmd.idx_op)
            ali_pkg::IDX_LOAD_POS:    idx_next = pos_addr;
            ali_pkg::IDX_LOAD_POS_P1: idx_next = pos_addr + ADDR_W'(1);
            ali_pkg::IDX_LOAD_LAST:   idx_next = len_m1[ADDR_W-1:0];
            ali_pkg::IDX_LOAD_ZERO:   idx_next = '0;
            ali_pkg::IDX_INC:         idx_next = idx_reg + ADDR_W'(1);
            ali_pkg::IDX_DEC:         idx_next = idx_reg - ADDR_W'(1);
            default:                  idx_next = idx_reg;
        endcase
    end

    // restart length, saturated to the capacity
    assign start_sat = (int'(start_len_reg) > ali_pkg::CAPACITY) ?
                       LEN_W'(ali_pkg::CAPACITY) : LEN_W'(start_len_reg);

    always_comb begin
        case (cmd.len_op)
            ali_pkg::LEN_INC:   len_next = len_reg + LEN_W'(1);
            ali_pkg::LEN_DEC:   len_next = len_m1;
            ali_pkg::LEN_START: len_next = start_sat;
            default:            len_next = len_reg;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            len_reg       <= '0;
            start_len_reg <= '0;
            rd_valid_reg  <= 1'b0;
            max_have_reg  <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            len_reg      <= len_next;
            rd_valid_reg <= cmd.rd_en;
            if (cfg_wr_en) begin
                start_len_reg <= cfg_wr_data;
            end
            if (cmd.max_clr) begin
                max_have_reg <= 1'b0;
            end else if (cmd.max_upd) begin
                max_have_reg <= 1'b1;
            end
        end
    end

    // running maximum over the words read back
    always_ff @(posedge aclk) begin
        if (cmd.max_upd && (!max_have_reg || ($signed(rdata_reg) > max_reg))) begin
            max_reg <= $signed(rdata_reg);
        end
    end

    // command item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
    end

    // result register
    always_comb begin
        case (cmd.out_sel)
            ali_pkg::OUT_RDATA: out_data = $signed(rdata_reg);
            ali_pkg::OUT_DIN:   out_data = item_reg.data_in;
            ali_pkg::OUT_MAX:   out_data = max_reg;
            default:            out_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status         <= cmd.out_status;
            out_reg.data_out       <= out_data;
            out_reg.current_length <= ali_pkg::START_W'(len_reg);
        end
    end

    assign m_item = out_reg;

endmodule

// ===== rtl/ali_ctrl.sv =====
// ----------------------------------------------------------------------------
// ali_ctrl
// command sequencer: decode, shift walks, maximum scan and clearing sweeps
// ----------------------------------------------------------------------------
module ali_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ali_pkg::dp_stat_t stat,
    output ali_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_READ,
        S_INS_SHIFT, S_INS_LAST, S_INS_PUT,
        S_DEL_SHIFT, S_DEL_LAST, S_DEL_CLEAR,
        S_MAX_SCAN, S_MAX_LAST, S_CLEAR, S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    ali_pkg::status_t   status_reg, status_next;
    ali_pkg::out_sel_t  sel_reg, sel_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg && !m_ready;

        cmd            = '0;
        cmd.waddr_sel  = ali_pkg::WA_IDX;
        cmd.wdata_sel  = ali_pkg::WD_ZERO;
        cmd.idx_op     = ali_pkg::IDX_HOLD;
        cmd.len_op     = ali_pkg::LEN_HOLD;
        cmd.out_sel    = sel_reg;
        cmd.out_status = status_reg;

        case (state_reg)
            // zero the whole store after reset
            S_INIT: begin
                cmd.mem_we = 1'b1;
                if (stat.idx_eq_top) begin
                    cmd.idx_op = ali_pkg::IDX_LOAD_ZERO;
                    state_next = S_IDLE;
                end else begin
                    cmd.idx_op = ali_pkg::IDX_INC;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            // range checks and first step of every command
            S_DECODE: begin
                status_next = ali_pkg::ST_OK;
                sel_next    = ali_pkg::OUT_ZERO;
                state_next  = S_RESULT;
                case (stat.command)
                    ali_pkg::CMD_READ: begin
                        if (stat.pos_ge_len) begin
                            status_next = ali_pkg::ST_RANGE;
                        end else begin
                            cmd.idx_op = ali_pkg::IDX_LOAD_POS;
                            sel_next   = ali_pkg::OUT_RDATA;
                            state_next = S_READ;
                        end
                    end
                    ali_pkg::CMD_INSERT: begin
                        if (stat.len_full) begin
                            status_next = ali_pkg::ST_FULL;
                        end else if (stat.pos_gt_len) begin
                            status_next = ali_pkg::ST_RANGE;
                        end else if (!stat.pos_ge_len) begin
                            cmd.idx_op = ali_pkg::IDX_LOAD_LAST;
                            state_next = S_INS_SHIFT;
                        end else begin
                            // append at the end
                            cmd.mem_we    = 1'b1;
                            cmd.waddr_sel = ali_pkg::WA_POS;
                            cmd.wdata_sel = ali_pkg::WD_DIN;
                            cmd.len_op    = ali_pkg::LEN_INC;
                        end
                    end
                    ali_pkg::CMD_DELETE: begin
                        if (stat.len_zero) begin
                            status_next = ali_pkg::ST_EMPTY;
                        end else if (stat.pos_ge_len) begin
                            status_next = ali_pkg::ST_RANGE;
                        end else if (stat.pos_p1_eq_len) begin
                            state_next = S_DEL_CLEAR;
                        end else begin
                            cmd.idx_op = ali_pkg::IDX_LOAD_POS_P1;
                            state_next = S_DEL_SHIFT;
                        end
                    end
                    ali_pkg::CMD_WRITE: begin
                        if (stat.pos_ge_len) begin
                            status_next = ali_pkg::ST_RANGE;
                        end else begin
                            cmd.mem_we    = 1'b1;
                            cmd.waddr_sel = ali_pkg::WA_POS;
                            cmd.wdata_sel = ali_pkg::WD_DIN;
                            sel_next      = ali_pkg::OUT_DIN;
                        end
                    end
                    ali_pkg::CMD_MAXIMUM: begin
                        if (stat.len_zero) begin
                            status_next = ali_pkg::ST_EMPTY;
                        end else begin
                            cmd.idx_op  = ali_pkg::IDX_LOAD_ZERO;
                            cmd.max_clr = 1'b1;
                            sel_next    = ali_pkg::OUT_MAX;
                            state_next  = S_MAX_SCAN;
                        end
                    end
                    ali_pkg::CMD_RESTART: begin
                        cmd.idx_op = ali_pkg::IDX_LOAD_ZERO;
                        state_next = S_CLEAR;
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RESULT;
            end
            // insert: walk down from the last entry, moving each one up
            S_INS_SHIFT: begin
                cmd.rd_en     = 1'b1;
                cmd.mem_we    = stat.rd_valid;
                cmd.waddr_sel = ali_pkg::WA_IDX_D_P1;
                cmd.wdata_sel = ali_pkg::WD_RDATA;
                if (stat.idx_eq_pos) begin
                    state_next = S_INS_LAST;
                end else begin
                    cmd.idx_op = ali_pkg::IDX_DEC;
                end
            end
            S_INS_LAST: begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = ali_pkg::WA_IDX_D_P1;
                cmd.wdata_sel = ali_pkg::WD_RDATA;
                state_next    = S_INS_PUT;
            end
            S_INS_PUT: begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = ali_pkg::WA_POS;
                cmd.wdata_sel = ali_pkg::WD_DIN;
                cmd.len_op    = ali_pkg::LEN_INC;
                state_next    = S_RESULT;
            end
            // delete: walk up from the slot after the position, moving each one down
            S_DEL_SHIFT: begin
                cmd.rd_en     = 1'b1;
                cmd.mem_we    = stat.rd_valid;
                cmd.waddr_sel = ali_pkg::WA_IDX_D_M1;
                cmd.wdata_sel = ali_pkg::WD_RDATA;
                if (stat.idx_eq_last) begin
                    state_next = S_DEL_LAST;
                end else begin
                    cmd.idx_op = ali_pkg::IDX_INC;
                end
            end
            S_DEL_LAST: begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = ali_pkg::WA_IDX_D_M1;
                cmd.wdata_sel = ali_pkg::WD_RDATA;
                state_next    = S_DEL_CLEAR;
            end
            S_DEL_CLEAR: begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = ali_pkg::WA_LAST;
                cmd.wdata_sel = ali_pkg::WD_ZERO;
                cmd.len_op    = ali_pkg::LEN_DEC;
                state_next    = S_RESULT;
            end
            // maximum: one entry read and compared per cycle
            S_MAX_SCAN: begin
                cmd.rd_en   = 1'b1;
                cmd.max_upd = stat.rd_valid;
                if (stat.idx_eq_last) begin
                    state_next = S_MAX_LAST;
                end else begin
                    cmd.idx_op = ali_pkg::IDX_INC;
                end
            end
            S_MAX_LAST: begin
                cmd.max_upd = 1'b1;
                state_next  = S_RESULT;
            end
            // restart: zero the store, then load the start length
            S_CLEAR: begin
                cmd.mem_we = 1'b1;
                if (stat.idx_eq_top) begin
                    cmd.len_op = ali_pkg::LEN_START;
                    state_next = S_RESULT;
                end else begin
                    cmd.idx_op = ali_pkg::IDX_INC;
                end
            end
            // hand the result to the output register once it is free
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
            status_reg  <= ali_pkg::ST_OK;
            sel_reg     <= ali_pkg::OUT_ZERO;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            sel_reg     <= sel_next;
        end
    end

endmodule

// ===== rtl/array_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// array_list_insert_delete
// bounded ordered list of signed 32-bit words with insert and delete shifting
// ----------------------------------------------------------------------------
// Usage: command items arrive on s_valid/s_ready/s_item, one result item per
// command leaves on m_valid/m_ready/m_item (status, data word, new length).
// The restart length is written through cfg_wr_en/cfg_wr_data while idle.
// One command is worked at a time; s_ready is high only when the sequencer
// is idle. Each command is decoded and range checked, works on the store if it
// must, and then loads its result into the output register.
// The walks are bound by the single read and single write port of the store,
// one entry moved or compared per cycle.
// After reset the store is swept to zero, one entry per cycle, with s_ready
// low; configuration writes are taken throughout.
// The result sits in an output register: while the receiver stalls a new
// command may be accepted and worked, and it waits to load until the
// previous result has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module array_list_insert_delete (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ali_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ali_pkg::out_item_t             m_item,
    input  logic                           cfg_wr_en,
    input  logic [ali_pkg::START_W-1:0]    cfg_wr_data
);

    ali_pkg::dp_cmd_t  dp_cmd;
    ali_pkg::dp_stat_t dp_stat;

    // sequencer
    ali_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // store and arithmetic
    ali_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .m_item      (m_item)
    );

    // one command at a time: no accept right after an accept
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a rejected command carries a zero data word
    `ASSERT_IMPL(a_reject_zero, aclk, aresetn,
                 m_valid && (m_item.status != ali_pkg::ST_OK), m_item.data_out == '0)

    // a result never loads over one that the receiver has not taken
    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, dp_cmd.out_load, !m_valid || m_ready)

endmodule

// ===== tb/sv/array_list_insert_delete_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_tb
// self-checking bench for the ordered list block: a clocked driver feeds
// command items from a queue, a clocked monitor checks every result item
// against a built-in model of the list, under random stalls on both sides
// ----------------------------------------------------------------------------
module array_list_insert_delete_tb;

    // codes outside the defined command set
    localparam logic [ali_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [ali_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_ITEMS    = 185;
    localparam int LEN_SOFT_CAP   = 40;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    ali_pkg::in_item_t           s_item      = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    ali_pkg::out_item_t          m_item;
    logic                        cfg_wr_en   = 1'b0;
    logic [ali_pkg::START_W-1:0] cfg_wr_data = '0;

    // shadow copy of the list
    logic signed [ali_pkg::DATA_W-1:0] list_mem [ali_pkg::CAPACITY];
    logic [ali_pkg::LEN_W-1:0]         list_len;
    logic [ali_pkg::START_W-1:0]       restart_len;

    ali_pkg::in_item_t  pending_cmds[$];
    ali_pkg::out_item_t expected_results[$];
    ali_pkg::out_item_t expected_head;

    int error_count  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int holds_asked  = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int stall_cycles = 0;

    array_list_insert_delete uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // apply one command to the shadow list and return the result it gives
    function automatic ali_pkg::out_item_t apply_list_op(ali_pkg::in_item_t it);
        ali_pkg::out_item_t                res;
        logic signed [ali_pkg::DATA_W-1:0] best;
        int                                pos;
        int                                len;
        int                                i;
        res = '0;
        res.status = ali_pkg::ST_OK;
        pos = int'(it.position);
        len = int'(list_len);
        case (it.command)
            ali_pkg::CMD_READ: begin
                if (pos >= len) res.status = ali_pkg::ST_RANGE;
                else res.data_out = list_mem[pos];
            end
            ali_pkg::CMD_INSERT: begin
                // full is checked before the index
                if (len >= ali_pkg::CAPACITY) begin
                    res.status = ali_pkg::ST_FULL;
                end else if (pos > len) begin
                    res.status = ali_pkg::ST_RANGE;
                end else begin
                    for (i = len; i > pos; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = it.data_in;
                    list_len = list_len + 1'b1;
                end
            end
            ali_pkg::CMD_DELETE: begin
                // empty is checked before the index
                if (len == 0) begin
                    res.status = ali_pkg::ST_EMPTY;
                end else if (pos >= len) begin
                    res.status = ali_pkg::ST_RANGE;
                end else begin
                    for (i = pos + 1; i < len; i++) list_mem[i - 1] = list_mem[i];
                    list_mem[len - 1] = '0;
                    list_len = list_len - 1'b1;
                end
            end
            ali_pkg::CMD_WRITE: begin
                if (pos >= len) begin
                    res.status = ali_pkg::ST_RANGE;
                end else begin
                    list_mem[pos] = it.data_in;
                    res.data_out = it.data_in;
                end
            end
            ali_pkg::CMD_MAXIMUM: begin
                if (len == 0) begin
                    res.status = ali_pkg::ST_EMPTY;
                end else begin
                    best = list_mem[0];
                    for (i = 1; i < len; i++)
                        if (list_mem[i] > best) best = list_mem[i];
                    res.data_out = best;
                end
            end
            ali_pkg::CMD_RESTART: begin
                for (i = 0; i < ali_pkg::CAPACITY; i++) list_mem[i] = '0;
                list_len = (restart_len > ali_pkg::CAPACITY) ?
                           ali_pkg::LEN_W'(ali_pkg::CAPACITY) : restart_len;
            end
            default: begin
            end
        endcase
        res.current_length = list_len;
        return res;
    endfunction

    // driver: offer the oldest pending item, hold it until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_list_op(s_item));
                void'(pending_cmds.pop_front());
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_item  <= pending_cmds[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with random stalls and requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // monitor: compare each result item with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: status %0d data_out %0d current_length %0d",
                       m_item.status, m_item.data_out, m_item.current_length);
                error_count++;
            end else begin
                expected_head = expected_results.pop_front();
                if (m_item.status !== expected_head.status) begin
                    $error("status: expected %0d, actual %0d",
                           expected_head.status, m_item.status);
                    error_count++;
                end
                if (m_item.data_out !== expected_head.data_out) begin
                    $error("data_out: expected %0d, actual %0d",
                           expected_head.data_out, m_item.data_out);
                    error_count++;
                end
                if (m_item.current_length !== expected_head.current_length) begin
                    $error("current_length: expected %0d, actual %0d",
                           expected_head.current_length, m_item.current_length);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // restart length write, only once nothing is in flight
    task automatic write_start_length(input logic [ali_pkg::START_W-1:0] value);
        wait (pending_cmds.size() == 0 && expected_results.size() == 0 && !s_valid);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        restart_len = value;
    endtask

    task automatic queue_cmd(input logic [ali_pkg::CMD_W-1:0]  cmd,
                             input logic [ali_pkg::POS_W-1:0]  pos,
                             input logic [ali_pkg::DATA_W-1:0] data);
        ali_pkg::in_item_t it;
        @(negedge aclk);
        it.command  = cmd;
        it.position = pos;
        it.data_in  = data;
        pending_cmds.push_back(it);
    endtask

    // mostly legal commands against the current length, plus noise
    task automatic queue_random_cmd();
        ali_pkg::in_item_t it;
        int                len;
        int                roll;
        wait (pending_cmds.size() == 0);
        @(negedge aclk);
        len  = int'(list_len);
        roll = $urandom_range(0, 99);
        it.data_in = $urandom;
        if ($urandom_range(0, 9) == 0)
            it.data_in = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        it.position = (len > 0) ? ali_pkg::POS_W'($urandom_range(0, len - 1)) : '0;
        if (roll < 15) begin
            it.command  = ali_pkg::CMD_W'($urandom_range(0, 7));
            it.position = ali_pkg::POS_W'($urandom);
        end else if (roll < 17) begin
            it.command = ali_pkg::CMD_RESTART;
        end else if (roll < 25) begin
            it.command = ali_pkg::CMD_MAXIMUM;
        end else if (roll < 40) begin
            it.command = ali_pkg::CMD_READ;
        end else if (roll < 55) begin
            it.command = ali_pkg::CMD_WRITE;
        end else if ($urandom_range(0, 99) < ((len > LEN_SOFT_CAP) ? 80 : 35)) begin
            it.command = ali_pkg::CMD_DELETE;
        end else begin
            it.command  = ali_pkg::CMD_INSERT;
            it.position = ali_pkg::POS_W'($urandom_range(0, len));
            // occasional insert just past the end
            if ($urandom_range(0, 9) == 0) it.position = ali_pkg::POS_W'(len + 1);
        end
        pending_cmds.push_back(it);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct,
                             input logic [ali_pkg::START_W-1:0] start_len,
                             input bit with_hold);
        int n;
        write_start_length(start_len);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            queue_random_cmd();
            if (with_hold && n == 20) holds_asked++;
        end
    endtask

    initial begin
        for (int k = 0; k < ali_pkg::CAPACITY; k++) list_mem[k] = '0;
        list_len    = '0;
        restart_len = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list: every command is rejected or trivial
        write_start_length(ali_pkg::START_W'(0));
        queue_cmd(ali_pkg::CMD_READ,    10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_DELETE,  10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_MAXIMUM, 10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_WRITE,   10'd0, 32'h1);
        queue_cmd(ali_pkg::CMD_INSERT,  10'd1, 32'h1);
        queue_cmd(ali_pkg::CMD_RESTART, 10'd0, 32'h0);

        // build a short list with extreme words, front, middle and append inserts
        queue_cmd(ali_pkg::CMD_INSERT,  10'd0, 32'h7fff_ffff);
        queue_cmd(ali_pkg::CMD_INSERT,  10'd1, 32'h8000_0000);
        queue_cmd(ali_pkg::CMD_INSERT,  10'd0, 32'hffff_ffff);
        queue_cmd(ali_pkg::CMD_INSERT,  10'd1, 32'h0);
        queue_cmd(ali_pkg::CMD_MAXIMUM, 10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_READ,    10'd3, 32'h0);
        queue_cmd(ali_pkg::CMD_WRITE,   10'd2, 32'h5555_5555);
        queue_cmd(ali_pkg::CMD_READ,    10'd4, 32'h0);
        queue_cmd(ali_pkg::CMD_DELETE,  10'd4, 32'h0);
        queue_cmd(ali_pkg::CMD_DELETE,  10'd1, 32'h0);
        queue_cmd(ali_pkg::CMD_DELETE,  10'd2, 32'h0);
        queue_cmd(CMD_SPARE_LO, 10'd1, 32'hdead_beef);
        queue_cmd(CMD_SPARE_HI, 10'h3ff, 32'hffff_ffff);

        // full list from restart, then the top index
        write_start_length(ali_pkg::START_W'(ali_pkg::CAPACITY));
        queue_cmd(ali_pkg::CMD_RESTART, 10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_INSERT,  10'd0, 32'h1);
        queue_cmd(ali_pkg::CMD_WRITE,   10'h3ff, 32'h1234_5678);
        queue_cmd(ali_pkg::CMD_MAXIMUM, 10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_DELETE,  10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_INSERT,  10'h3ff, 32'h8000_0000);
        queue_cmd(ali_pkg::CMD_READ,    10'h3ff, 32'h0);

        // restart length above capacity saturates
        write_start_length({ali_pkg::START_W{1'b1}});
        queue_cmd(ali_pkg::CMD_RESTART, 10'd0, 32'h0);
        queue_cmd(ali_pkg::CMD_READ,    10'h3ff, 32'h0);

        run_phase(28, 84, ali_pkg::START_W'($urandom_range(1, 32)), 1'b0);
        run_phase(84, 28, ali_pkg::START_W'(0), 1'b0);
        run_phase(0, 0, ali_pkg::START_W'($urandom_range(1, 32)), 1'b1);

        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
